// ===== rtl/oets_pkg.sv =====
package oets_pkg;

  localparam int MAX_LEN = 64;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int PH_W    = $clog2(MAX_LEN);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Commands from the controller to the cell row
  typedef struct packed {
    logic             load;   // shift a new element in at cell 0
    logic             sort;   // run one compare-exchange phase
    logic             odd;    // phase parity: pairs (1,2),(3,4),...
    logic             pop;    // shift the row down by one after a transfer out
    logic [CNT_W-1:0] n;      // number of elements held
  } cmd_t;

endpackage

// ===== rtl/oets_ctrl.sv =====
module oets_ctrl
  import oets_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic out_last,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PH_W-1:0]  phase, phase_next;
  logic             in_acc, out_acc, phase_done;

  assign in_ready   = (state == ST_LOAD);
  assign out_valid  = (state == ST_EMIT);
  assign out_last   = (count == CNT_W'(1));
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign phase_done = ({1'b0, phase} + CNT_W'(1)) == count;

  always_comb begin
    cmd.load = in_acc && (count < CNT_W'(MAX_LEN));
    cmd.sort = (state == ST_SORT);
    cmd.odd  = phase[0];
    cmd.pop  = out_acc;
    cmd.n    = count;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    phase_next = phase;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          // drop elements beyond capacity, but still honour the closing flag
          if (count < CNT_W'(MAX_LEN)) count_next = count + CNT_W'(1);
          if (in_last) begin
            state_next = ST_SORT;
            phase_next = '0;
          end
        end
      end
      ST_SORT: begin
        if (phase_done) begin
          state_next = ST_EMIT;
          phase_next = '0;
        end else begin
          phase_next = phase + PH_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          count_next = count - CNT_W'(1);
          if (out_last) state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/oets_cells.sv =====
module oets_cells
  import oets_pkg::*;
(
  input  logic                     clk,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] head
);

  logic signed [DATA_W-1:0] cells [MAX_LEN];
  logic signed [DATA_W-1:0] sorted [MAX_LEN];
  logic [MAX_LEN-2:0]       swp;

  // one comparator per adjacent pair; only pairs of the current parity inside the list act
  always_comb begin
    for (int i = 0; i < MAX_LEN - 1; i++) begin
      swp[i] = (1'(i) == cmd.odd) && (CNT_W'(i + 1) < cmd.n) && (cells[i] > cells[i + 1]);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      sorted[j] = cells[j];
      if (j < MAX_LEN - 1) begin
        if (swp[j]) sorted[j] = cells[j + 1];
      end
      if (j > 0) begin
        if (swp[j - 1]) sorted[j] = cells[j - 1];
      end
    end
  end

  assign head = cells[0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // load order does not matter: the row is sorted before it is read
      cells[0] <= in_value;
      for (int j = 1; j < MAX_LEN; j++) cells[j] <= cells[j - 1];
    end else if (cmd.pop) begin
      for (int j = 0; j < MAX_LEN - 1; j++) cells[j] <= cells[j + 1];
    end else if (cmd.sort) begin
      for (int j = 0; j < MAX_LEN; j++) cells[j] <= sorted[j];
    end
  end

endmodule

// ===== rtl/odd_even_transposition_sorter.sv =====
// Odd-even transposition sorter.
// Input stream (s_axis_*): one signed 32-bit element per transfer; tlast closes
// the list. Up to 64 elements are kept; further elements are dropped, though a
// dropped transfer carrying tlast still closes the list.
// Output stream (m_axis_*): the list in ascending order, one element per
// transfer, tlast on the final one.
// While loading, s_axis_tready stays high, so elements can arrive back to back.
// After the closing transfer the cell row runs n compare-exchange phases, even and
// odd pairs in turn, each phase acting on all pairs of its parity at once (n is the
// number of elements held). The first result is then offered and each further
// result is offered in the cycle after the previous transfer. The block loads,
// sorts and emits in turn, and s_axis_tready is low while a list is sorted or emitted.
// A stalled receiver simply holds the current result on m_axis_tdata; nothing is
// lost. Reset (rst, synchronous) empties the block and leaves it ready to load.
module odd_even_transposition_sorter
  import oets_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic                     s_axis_tlast,   // last_item
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic signed [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic                     m_axis_tlast    // end_of_list
);

  cmd_t cmd;

  oets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .cmd       (cmd)
  );

  oets_cells u_cells (
    .clk      (clk),
    .cmd      (cmd),
    .in_value (s_axis_tdata),
    .head     (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("load and emit active together");

  a_sort_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
    else $error("no sort phase after closing transfer");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("not ready for a new list after final result");
`endif

endmodule

// ===== tb/sv/odd_even_transposition_sorter_test.sv =====
module odd_even_transposition_sorter_test
  import oets_pkg::*;
;

  typedef logic signed [DATA_W-1:0] elem_t;

  // one emitted element of a sorted list
  typedef struct packed {
    elem_t value;
    logic  tail;
  } sorted_elem_t;

  // a run of count elements, value stepping by step; closes marks the final one
  typedef struct packed {
    elem_t value;
    int    step;
    int    count;
    bit    closes;
    bit    typed;
    elem_t typed_value;
  } stim_row_t;

  localparam elem_t ELEM_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
  localparam elem_t ELEM_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int    QUIET_LIMIT  = 3000;
  localparam int    TAIL_CYCLES  = 3 * MAX_LEN + 20;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    PHASE_ITEMS  = 20;
  localparam int    N_ROWS       = 17;

  logic  clk           = 1'b0;
  logic  rst           = 1'b1;
  logic  s_axis_tvalid = 1'b0;
  logic  s_axis_tready;
  elem_t s_axis_tdata  = '0;
  logic  s_axis_tlast  = 1'b0;
  logic  m_axis_tvalid;
  logic  m_axis_tready = 1'b0;
  elem_t m_axis_tdata;
  logic  m_axis_tlast;

  elem_t        open_list[$];
  sorted_elem_t expected_sorted[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_pending   = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int lists_closed   = 0;
  int overflow_lists = 0;
  int results_seen   = 0;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{ELEM_MIN, 0, 1, 1'b1, 1'b1, ELEM_MIN},
    '{ELEM_MAX, 0, 1, 1'b1, 1'b1, ELEM_MAX},
    '{32'sd0,   0, 1, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1,  0, 1, 1'b1, 1'b1, -32'sd1},
    '{ELEM_MAX, 0, 1, 1'b0, 1'b0, 32'sd0},
    '{ELEM_MIN, 0, 1, 1'b1, 1'b0, 32'sd0},
    '{32'sd50, -10, 5, 1'b1, 1'b0, 32'sd0},
    '{32'sd7,   0, 3, 1'b0, 1'b0, 32'sd0},
    '{-32'sd7,  0, 1, 1'b1, 1'b0, 32'sd0},
    '{-32'sd1,  0, 1, 1'b0, 1'b0, 32'sd0},
    '{32'sd1,   0, 1, 1'b0, 1'b0, 32'sd0},
    '{ELEM_MAX - 1, 0, 1, 1'b0, 1'b0, 32'sd0},
    '{ELEM_MIN + 1, 0, 1, 1'b0, 1'b0, 32'sd0},
    '{32'sd0,   0, 1, 1'b1, 1'b0, 32'sd0},
    // past the limit: the closing transfer itself is dropped
    '{32'sd1000, -3, MAX_LEN + 2, 1'b1, 1'b0, 32'sd0},
    // counters must be back at zero after the long list
    '{32'sd123, 0, 1, 1'b1, 1'b1, 32'sd123},
    '{32'sd9,   5, 6, 1'b1, 1'b0, 32'sd0}
  };

  odd_even_transposition_sorter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // odd-even transposition sort of the open list, then queue it, or only typed_value when typed
  task automatic sort_and_queue(input bit typed, input elem_t typed_value);
    int    n;
    int    ph;
    int    i;
    elem_t t;
    sorted_elem_t item;
    n = open_list.size();
    for (ph = 0; ph < n; ph++) begin
      for (i = ph % 2; i + 1 < n; i += 2) begin
        if (open_list[i] > open_list[i+1]) begin
          t = open_list[i];
          open_list[i] = open_list[i+1];
          open_list[i+1] = t;
        end
      end
    end
    if (typed) begin
      item.value = typed_value;
      item.tail  = 1'b1;
      expected_sorted.push_back(item);
    end else begin
      for (i = 0; i < n; i++) begin
        item.value = open_list[i];
        item.tail  = (i == n - 1);
        expected_sorted.push_back(item);
      end
    end
    open_list.delete();
  endtask

  task automatic take_element(input elem_t v, input logic closes, input bit typed,
                              input elem_t typed_value);
    if (open_list.size() < MAX_LEN)
      open_list.push_back(v);
    else if (closes)
      overflow_lists++;
    if (closes) begin
      lists_closed++;
      sort_and_queue(typed, typed_value);
    end
  endtask

  task automatic send_item(input elem_t v, input logic closes, input bit typed,
                           input elem_t typed_value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= closes;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    take_element(v, closes, typed, typed_value);
    items_sent++;
  endtask

  task automatic send_random_list(input int len);
    int    flavour;
    int    k;
    elem_t v;
    flavour = $urandom_range(3);
    for (k = 0; k < len; k++) begin
      case (flavour)
        0: v = $urandom;
        1: v = $urandom_range(8) - 4;            // heavy on duplicates
        2: begin
          case ($urandom_range(3))
            0: v = ELEM_MIN;
            1: v = ELEM_MAX;
            2: v = '0;
            default: v = -1;
          endcase
        end
        default: v = k * 977 - 20000 + $urandom_range(500);
      endcase
      send_item(v, k == len - 1, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input bit long_hold,
                           input int forced_len);
    int start;
    int len;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    start          = items_sent;
    if (long_hold)
      hold_pending = 1'b1;
    if (forced_len > 0)
      send_random_list(forced_len);
    while (items_sent - start < PHASE_ITEMS) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 4)
                                      : $urandom_range(1, 10);
      send_random_list(len);
    end
    drain_results();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sorted_elem_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_sorted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer out: value %0d last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_sorted.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.tail) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.value, want.tail, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_sorted.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int    r;
    int    k;
    elem_t v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < directed_rows[r].count; k++) begin
        v = directed_rows[r].value + k * directed_rows[r].step;
        send_item(v, directed_rows[r].closes && (k == directed_rows[r].count - 1),
                  directed_rows[r].typed, directed_rows[r].typed_value);
      end
    end
    drain_results();

    run_phase(0,  0,  1'b0, 0);
    run_phase(45, 0,  1'b0, 0);
    run_phase(0,  45, 1'b1, 0);
    run_phase(17, 17, 1'b0, MAX_LEN + 3);

    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d lists (%0d overran the %0d-element store)",
             items_sent, lists_closed, overflow_lists, MAX_LEN);
    $display("Checked %0d sorted elements under four sender/receiver idling mixes",
             results_seen);
    if (mismatches == 0 && expected_sorted.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/oets_pkg.sv
rtl/oets_ctrl.sv
rtl/oets_cells.sv
rtl/odd_even_transposition_sorter.sv
tb/sv/odd_even_transposition_sorter_test.sv
